// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the tracking lock state manager.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tlsm_pkg.sv =====
// Package of the tracking lock state manager: mode and transition codes,
// register indexes, fixed-point constants and the result record.
// No dependencies.
package tlsm_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int PhaseW   = 22;
  localparam int DriftW   = 32;

  localparam logic [1:0] MODE_ACQ   = 2'd0;
  localparam logic [1:0] MODE_CONF  = 2'd1;
  localparam logic [1:0] MODE_TRACK = 2'd2;

  localparam logic [1:0] TR_NONE      = 2'd0;
  localparam logic [1:0] TR_CONFIRMED = 2'd1;
  localparam logic [1:0] TR_TIMEOUT   = 2'd2;
  localparam logic [1:0] TR_LOST      = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_CARRIER_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RATIO_TOL    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CONFIRM_DEB  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CONFIRM_TOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOSS_DEB     = 3'd4;

  // Q2.14 unity and chip constants with 12 fraction bits
  localparam logic [15:0] Q14_ONE      = 16'd16384;
  localparam logic [24:0] CHIPS_PERIOD = 25'd4190208;
  localparam logic [24:0] CHIPS_OFFSET = 25'd6285312;
  localparam logic [24:0] CHIPS_HALF   = 25'd2095104;

  typedef struct packed {
    logic signed [DriftW-1:0] drift_chips;
    logic                     good_block;
    logic [1:0]               transition;
    logic [1:0]               channel_mode;
  } result_t;

endpackage

// ===== sv/tracking_lock_state_manager.sv =====
// Lock detector of one tracking channel: takes start and block transactions,
// keeps mode, debounce counters and code drift, and returns one result each.
// Depends on tlsm_pkg, tlsm_drift and assert_macros.svh.
//
// Each accepted transaction gives exactly one result, via the input register and
// then the result register; unless the result stalls, one transaction is taken
// every cycle. The whole state update of an item happens in the single stage
// between the input register and the result register, so the next item always
// sees the state left by the previous one. A stalled result holds the result
// register, and the input register still takes one more transaction behind it.
`include "assert_macros.svh"

module tracking_lock_state_manager (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tlsm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tlsm_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] carrier_lock, [31:16] code_lock_ratio, [53:32] code_phase, [55:54] zero
  input  logic [55:0]                    s_tdata,
  // [0] cmd
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] channel_mode, [3:2] transition, [4] good_block, [36:5] drift_chips,
  // [39:37] zero
  output logic [39:0]                    m_tdata
);
  import tlsm_pkg::*;

  // configuration
  logic signed [15:0] carrier_lock_threshold;
  logic [15:0]        code_ratio_tolerance;
  logic [15:0]        confirm_debounce;
  logic [15:0]        confirm_timeout;
  logic [15:0]        loss_debounce;

  // input register
  logic               in_valid;
  logic               in_cmd;
  logic signed [15:0] in_lock;
  logic [15:0]        in_ratio;
  logic [PhaseW-1:0]  in_phase;

  // channel state
  logic [1:0]               mode, mode_next;
  logic [15:0]              confirm_count, confirm_count_next;
  logic [15:0]              loss_count, loss_count_next;
  logic [15:0]              confirm_block_count, confirm_block_count_next;
  logic [PhaseW-1:0]        previous_phase, previous_phase_next;
  logic signed [DriftW-1:0] drift_sum, drift_sum_next;
  logic                     have_previous, have_previous_next;

  result_t result, result_next;
  logic    advance;
  logic    good;
  logic [15:0] dev;
  logic [15:0] cc_upd, lc_upd, cbc_upd;
  logic signed [DriftW-1:0] drift_added;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {3'b000, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_lock_threshold <= 16'sd4915;
      code_ratio_tolerance   <= 16'd4915;
      confirm_debounce       <= 16'd50;
      confirm_timeout        <= 16'd200;
      loss_debounce          <= 16'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CARRIER_THR:  carrier_lock_threshold <= $signed(cfg_data);
        REG_RATIO_TOL:    code_ratio_tolerance   <= cfg_data;
        REG_CONFIRM_DEB:  confirm_debounce       <= cfg_data;
        REG_CONFIRM_TOUT: confirm_timeout        <= cfg_data;
        REG_LOSS_DEB:     loss_debounce          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_lock  <= $signed(s_tdata[15:0]);
      in_ratio <= s_tdata[31:16];
      in_phase <= s_tdata[53:32];
    end
  end

  tlsm_drift u_drift (
    .phase          (in_phase),
    .previous_phase (previous_phase),
    .drift_sum      (drift_sum),
    .drift_added    (drift_added)
  );

  always_comb begin
    dev     = (in_ratio >= Q14_ONE) ? in_ratio - Q14_ONE : Q14_ONE - in_ratio;
    good    = (in_lock >= carrier_lock_threshold) && (dev <= code_ratio_tolerance);
    cc_upd  = good ? ((confirm_count == 16'hFFFF) ? confirm_count : confirm_count + 16'd1)
                   : ((confirm_count == 16'd0) ? confirm_count : confirm_count - 16'd1);
    lc_upd  = good ? ((loss_count == 16'd0) ? loss_count : loss_count - 16'd1)
                   : ((loss_count == 16'hFFFF) ? loss_count : loss_count + 16'd1);
    cbc_upd = (confirm_block_count == 16'hFFFF) ? confirm_block_count
                                                : confirm_block_count + 16'd1;
  end

  always_comb begin
    mode_next                = mode;
    confirm_count_next       = confirm_count;
    loss_count_next          = loss_count;
    confirm_block_count_next = confirm_block_count;
    previous_phase_next      = previous_phase;
    drift_sum_next           = drift_sum;
    have_previous_next       = have_previous;
    result_next.transition   = TR_NONE;
    result_next.good_block   = 1'b0;

    if (!in_cmd) begin
      // start: enter confirming with everything cleared
      mode_next                = MODE_CONF;
      confirm_count_next       = 16'd0;
      loss_count_next          = 16'd0;
      confirm_block_count_next = 16'd0;
      previous_phase_next      = '0;
      drift_sum_next           = '0;
      have_previous_next       = 1'b0;
    end else begin
      unique case (mode)
        MODE_CONF: begin
          result_next.good_block   = good;
          confirm_count_next       = cc_upd;
          confirm_block_count_next = cbc_upd;
          // confirm wins a tie with the timeout
          if (cc_upd >= confirm_debounce) begin
            loss_count_next        = 16'd0;
            mode_next              = MODE_TRACK;
            result_next.transition = TR_CONFIRMED;
          end else if (cbc_upd >= confirm_timeout) begin
            mode_next              = MODE_ACQ;
            result_next.transition = TR_TIMEOUT;
            previous_phase_next    = '0;
            drift_sum_next         = '0;
            have_previous_next     = 1'b0;
          end
        end
        MODE_TRACK: begin
          result_next.good_block = good;
          loss_count_next        = lc_upd;
          if (lc_upd >= loss_debounce) begin
            mode_next              = MODE_ACQ;
            result_next.transition = TR_LOST;
            previous_phase_next    = '0;
            drift_sum_next         = '0;
            have_previous_next     = 1'b0;
          end else begin
            // first tracking block only records the phase
            if (have_previous) begin
              drift_sum_next = drift_added;
            end
            previous_phase_next = in_phase;
            have_previous_next  = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_ACQ;
        end
      endcase
    end

    result_next.channel_mode = mode_next;
    result_next.drift_chips  = drift_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_ACQ;
      confirm_count       <= 16'd0;
      loss_count          <= 16'd0;
      confirm_block_count <= 16'd0;
      previous_phase      <= '0;
      drift_sum           <= '0;
      have_previous       <= 1'b0;
    end else if (advance) begin
      mode                <= mode_next;
      confirm_count       <= confirm_count_next;
      loss_count          <= loss_count_next;
      confirm_block_count <= confirm_block_count_next;
      previous_phase      <= previous_phase_next;
      drift_sum           <= drift_sum_next;
      have_previous       <= have_previous_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  `ASSERT_IMPL(a_drift_only_tracking, clk, rst, mode != MODE_TRACK, drift_sum == '0, "drift outside tracking")
  `ASSERT_IMPL(a_lost_clears, clk, rst, m_tvalid && result.transition == TR_LOST, result.channel_mode == MODE_ACQ && result.drift_chips == '0, "lock loss did not clear")
  `ASSERT_IMPL(a_confirm_tracks, clk, rst, m_tvalid && result.transition == TR_CONFIRMED, result.channel_mode == MODE_TRACK, "confirm without tracking")
  `ASSERT_NEXT(a_result_follows, clk, rst, advance, m_tvalid && result.channel_mode == mode, "result lost or mode mismatch")

endmodule

// ===== sv/tlsm_drift.sv =====
// Code drift update: wraps the phase step into +-511.5 chips and adds it
// to the drift with 32-bit saturation. Depends on tlsm_pkg.
module tlsm_drift (
  input  logic [tlsm_pkg::PhaseW-1:0]        phase,
  input  logic [tlsm_pkg::PhaseW-1:0]        previous_phase,
  input  logic signed [tlsm_pkg::DriftW-1:0] drift_sum,
  output logic signed [tlsm_pkg::DriftW-1:0] drift_added
);
  import tlsm_pkg::*;

  logic [24:0]        offs;
  logic [24:0]        wrapped;
  logic signed [24:0] step;
  logic signed [32:0] sum;

  // offs lies below three chip periods, so two compares finish the modulo
  always_comb begin
    offs = {3'b000, phase} - {3'b000, previous_phase} + CHIPS_OFFSET;
    if (offs >= (CHIPS_PERIOD << 1)) begin
      wrapped = offs - (CHIPS_PERIOD << 1);
    end else if (offs >= CHIPS_PERIOD) begin
      wrapped = offs - CHIPS_PERIOD;
    end else begin
      wrapped = offs;
    end
    step = $signed(wrapped - CHIPS_HALF);
    sum  = {drift_sum[DriftW-1], drift_sum} + {{8{step[24]}}, step};
    if (sum[32] != sum[31]) begin
      drift_added = sum[32] ? {1'b1, {(DriftW-1){1'b0}}} : {1'b0, {(DriftW-1){1'b1}}};
    end else begin
      drift_added = sum[31:0];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for tracking_lock_state_manager: stream transactions in,
// lock reports out, each checked against an in-bench lock predictor or typed table row.
// Depends on tlsm_pkg and the RTL of the block; needs no files or arguments.
module tb_top;
  import tlsm_pkg::*;

  localparam bit CMD_START = 1'b0;
  localparam bit CMD_BLOCK = 1'b1;

  // register indexes outside the map; writes there must change nothing
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_HI = 3'd7;

  localparam int FLV_GOOD  = 0;
  localparam int FLV_BAD   = 1;
  localparam int FLV_EDGE  = 2;
  localparam int FLV_NOISE = 3;

  localparam int HOLD_CYCLES = 40;

  localparam longint DRIFT_MAX = 64'sd2147483647;
  localparam longint DRIFT_MIN = -64'sd2147483648;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    bit                 cmd;
    logic signed [15:0] lock;
    logic [15:0]        ratio;
    logic [21:0]        phase;
    bit                 typed;
    result_t            want;
  } block_item_t;

  typedef struct {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [15:0]        reg_val;
    bit                 cmd;
    logic [15:0]        lock;
    logic [15:0]        ratio;
    logic [21:0]        phase;
    bit                 typed;
    logic [1:0]         mode;
    logic [1:0]         tr;
    bit                 good;
    logic [31:0]        drift;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [55:0]         s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [39:0]         m_tdata;

  tracking_lock_state_manager dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic signed [15:0] lock_thr = 16'sd4915;
  logic [15:0]        ratio_tol = 16'd4915;
  logic [15:0]        conf_need = 16'd50;
  logic [15:0]        conf_limit = 16'd200;
  logic [15:0]        loss_limit = 16'd200;

  // predictor copy of the channel state
  logic [1:0]         chan_mode = MODE_ACQ;
  logic [15:0]        conf_progress = '0;
  logic [15:0]        loss_progress = '0;
  logic [15:0]        conf_blocks = '0;
  logic [21:0]        last_phase = '0;
  logic signed [31:0] drift = '0;
  bit                 have_last = 1'b0;

  block_item_t block_feed [$];
  result_t     lock_reports_due [$];
  block_item_t on_bus;
  result_t     predicted;
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          code_walk = 0;
  int          sent = 0;
  int          reported = 0;

  step_row_t steps [$] = '{
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd0, 1, MODE_ACQ, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_START, 16'h0000, 16'h0000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd0, 1, MODE_CONF, TR_NONE, 1, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h8000, 16'h4000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h0000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'hFFFF, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h1333, 16'h5333, 22'd0, 1, MODE_CONF, TR_NONE, 1, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h1332, 16'h4000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h1333, 16'h2CCD, 22'd0, 1, MODE_CONF, TR_NONE, 1, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h1333, 16'h5334, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_REG, REG_UNUSED_LO, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_UNUSED_HI, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_CONFIRM_DEB, 16'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_CONFIRM_TOUT, 16'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_LOSS_DEB, 16'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_START, 16'h0000, 16'h0000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd0, 1,
      MODE_TRACK, TR_CONFIRMED, 1, 0},
    // first tracking block, phase beyond one code period: record only
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'h3FFFFF, 1,
      MODE_TRACK, TR_NONE, 1, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd100, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd4190000, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h8000, 16'h4000, 22'd0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h8000, 16'h4000, 22'd2095104, 1,
      MODE_ACQ, TR_LOST, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_START, 16'hFFFF, 16'hFFFF, 22'h3FFFFF, 1,
      MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h8000, 16'hFFFF, 22'd0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h8000, 16'h0000, 22'd0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h8000, 16'h4000, 22'd0, 1, MODE_ACQ, TR_TIMEOUT, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_START, 16'h0000, 16'h0000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, 0, 0, CMD_BLOCK, 16'h7FFF, 16'h4000, 22'd0, 1,
      MODE_TRACK, TR_CONFIRMED, 1, 0},
    // start while tracking
    '{ROW_ITEM, 0, 0, CMD_START, 16'h0000, 16'h0000, 22'd0, 1, MODE_CONF, TR_NONE, 0, 0}
  };

  function automatic logic [15:0] bump_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] bump_down(logic [15:0] v);
    return (v == 16'd0) ? v : v - 16'd1;
  endfunction

  function automatic void drop_drift();
    drift = '0;
    have_last = 1'b0;
    last_phase = '0;
  endfunction

  // Advance the predicted channel state by one transaction, return its report.
  function automatic result_t advance_lock_state(block_item_t it);
    result_t r;
    int      dev;
    longint  step;
    longint  acc;
    bit      good;
    r = '0;
    good = 1'b0;
    r.transition = TR_NONE;
    if (it.cmd == CMD_START) begin
      chan_mode = MODE_CONF;
      conf_progress = '0;
      loss_progress = '0;
      conf_blocks = '0;
      drop_drift();
    end else if (chan_mode == MODE_CONF || chan_mode == MODE_TRACK) begin
      dev = int'(it.ratio) - int'(Q14_ONE);
      if (dev < 0) dev = -dev;
      good = (it.lock >= lock_thr) && (dev <= int'(ratio_tol));
      if (chan_mode == MODE_CONF) begin
        conf_progress = good ? bump_up(conf_progress) : bump_down(conf_progress);
        conf_blocks = bump_up(conf_blocks);
        // confirm checked first so it wins a tie with the timeout
        if (conf_progress >= conf_need) begin
          loss_progress = '0;
          chan_mode = MODE_TRACK;
          r.transition = TR_CONFIRMED;
        end else if (conf_blocks >= conf_limit) begin
          chan_mode = MODE_ACQ;
          r.transition = TR_TIMEOUT;
          drop_drift();
        end
      end else begin
        if (have_last) begin
          step = (longint'(it.phase) - longint'(last_phase) + longint'(CHIPS_OFFSET))
                 % longint'(CHIPS_PERIOD) - longint'(CHIPS_HALF);
          acc = longint'(drift) + step;
          if (acc > DRIFT_MAX) acc = DRIFT_MAX;
          if (acc < DRIFT_MIN) acc = DRIFT_MIN;
          drift = acc[31:0];
        end
        last_phase = it.phase;
        have_last = 1'b1;
        loss_progress = good ? bump_down(loss_progress) : bump_up(loss_progress);
        if (loss_progress >= loss_limit) begin
          chan_mode = MODE_ACQ;
          r.transition = TR_LOST;
          drop_drift();
        end
      end
    end else begin
      chan_mode = MODE_ACQ;
    end
    r.channel_mode = chan_mode;
    r.good_block = good;
    r.drift_chips = drift;
    return r;
  endfunction

  // Build one block transaction aimed at the current thresholds.
  function automatic block_item_t make_block(int flavor);
    block_item_t it;
    int          thr;
    int          tol;
    int          lo;
    int          hi;
    int          stride;
    thr = int'(lock_thr);
    tol = int'(ratio_tol);
    lo = (16384 - tol < 0) ? 0 : 16384 - tol;
    hi = (16384 + tol > 65535) ? 65535 : 16384 + tol;
    it.cmd = CMD_BLOCK;
    it.typed = 1'b0;
    it.want = '0;
    it.lock = 16'($urandom);
    it.ratio = 16'($urandom);
    case (flavor)
      FLV_GOOD: begin
        it.lock = 16'(thr + int'($urandom_range(32767 - thr)));
        it.ratio = 16'($urandom_range(hi, lo));
      end
      FLV_BAD: begin
        if (thr > -32768 && ($urandom_range(1) == 1 || (lo == 0 && hi == 65535)))
          it.lock = 16'(-32768 + int'($urandom_range(thr + 32767)));
        else if (lo > 0 && (hi == 65535 || $urandom_range(1) == 1))
          it.ratio = 16'($urandom_range(lo - 1));
        else if (hi < 65535)
          it.ratio = 16'($urandom_range(65535, hi + 1));
      end
      FLV_EDGE: begin
        it.lock = 16'(($urandom_range(1) == 1) ? thr : thr - 1);
        case ($urandom_range(3))
          0: it.ratio = 16'(lo);
          1: it.ratio = 16'(hi);
          2: it.ratio = 16'(lo - 1);
          default: it.ratio = 16'(hi + 1);
        endcase
      end
      default: ;
    endcase
    case ($urandom_range(19))
      0: it.phase = 22'($urandom);
      1: it.phase = 22'($urandom_range(4194303, 4190208));
      default: begin
        // walk the code phase, mostly small steps with the odd big jump
        stride = ($urandom_range(2) == 0) ? int'($urandom_range(4190207))
                                         : int'($urandom_range(60000)) - 30000;
        code_walk = (code_walk + stride) % int'(CHIPS_PERIOD);
        if (code_walk < 0) code_walk += int'(CHIPS_PERIOD);
        it.phase = 22'(code_walk);
      end
    endcase
    return it;
  endfunction

  // sender side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted = advance_lock_state(on_bus);
        lock_reports_due.insert(lock_reports_due.size(),
                                on_bus.typed ? on_bus.want : predicted);
      end
      if (!s_tvalid || s_tready) begin
        if (block_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
          on_bus = block_feed.pop_front();
          sent++;
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, on_bus.phase, on_bus.ratio, on_bus.lock};
          s_tuser <= on_bus.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver side; each new hold request stalls it until its hold countdown runs out
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : report_check
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[36:0];
      reported++;
      if (lock_reports_due.size() == 0) begin
        $error("report with no transaction pending: %h", m_tdata);
        mismatches++;
      end else begin
        want = lock_reports_due.pop_front();
        if (seen.channel_mode !== want.channel_mode) begin
          $error("channel_mode: expected %0d, got %0d", want.channel_mode, seen.channel_mode);
          mismatches++;
        end
        if (seen.transition !== want.transition) begin
          $error("transition: expected %0d, got %0d", want.transition, seen.transition);
          mismatches++;
        end
        if (seen.good_block !== want.good_block) begin
          $error("good_block: expected %0d, got %0d", want.good_block, seen.good_block);
          mismatches++;
        end
        if (seen.drift_chips !== want.drift_chips) begin
          $error("drift_chips: expected %0d, got %0d", want.drift_chips, seen.drift_chips);
          mismatches++;
        end
      end
    end
  end

  // Hold until every queued transaction is reported, then let the pipe drain.
  task automatic settle();
    while (block_feed.size() != 0 || reported < sent)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CARRIER_THR:  lock_thr = val;
      REG_RATIO_TOL:    ratio_tol = val;
      REG_CONFIRM_DEB:  conf_need = val;
      REG_CONFIRM_TOUT: conf_limit = val;
      REG_LOSS_DEB:     loss_limit = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] thr, logic [15:0] tol, logic [15:0] deb,
                               logic [15:0] tout, logic [15:0] loss);
    settle();
    write_reg(REG_CARRIER_THR, thr);
    write_reg(REG_RATIO_TOL, tol);
    write_reg(REG_CONFIRM_DEB, deb);
    write_reg(REG_CONFIRM_TOUT, tout);
    write_reg(REG_LOSS_DEB, loss);
  endtask

  // Mostly start-then-blocks sessions with random content; some starts dropped.
  task automatic run_sessions(int count, int good_pct, int lmax);
    block_item_t it;
    int          queued;
    int          len;
    int          pct;
    int          r;
    queued = 0;
    while (queued < count) begin
      pct = ($urandom_range(3) == 0) ? int'($urandom_range(100)) : good_pct;
      len = $urandom_range(lmax, 1);
      if ($urandom_range(9) != 0) begin
        it = make_block(FLV_NOISE);
        it.cmd = CMD_START;
        block_feed.insert(block_feed.size(), it);
        queued++;
      end
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 6)
          block_feed.insert(block_feed.size(), make_block(FLV_NOISE));
        else if (r < 14)
          block_feed.insert(block_feed.size(), make_block(FLV_EDGE));
        else if ($urandom_range(99) < pct)
          block_feed.insert(block_feed.size(), make_block(FLV_GOOD));
        else
          block_feed.insert(block_feed.size(), make_block(FLV_BAD));
      end
      queued += len;
    end
    settle();
  endtask

  // Every block good and loss never reached: step the phase by nearly half a
  // period each time so the drift builds up fast in one direction.
  task automatic drift_run(bit upward);
    block_item_t it;
    int          span;
    apply_setting(16'h8000, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    it = make_block(FLV_NOISE);
    it.cmd = CMD_START;
    block_feed.insert(block_feed.size(), it);
    repeat (60) begin
      it = make_block(FLV_NOISE);
      span = 2093000 + int'($urandom_range(2103));
      if (upward)
        code_walk = (code_walk + span) % int'(CHIPS_PERIOD);
      else
        code_walk = (code_walk + int'(CHIPS_PERIOD) - span - 1) % int'(CHIPS_PERIOD);
      it.phase = 22'(code_walk);
      block_feed.insert(block_feed.size(), it);
    end
    settle();
  endtask

  initial begin : main_seq
    block_item_t it;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle = 19;
    recv_idle = 54;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_REG) begin
        settle();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        it.cmd = steps[i].cmd;
        it.lock = steps[i].lock;
        it.ratio = steps[i].ratio;
        it.phase = steps[i].phase;
        it.typed = steps[i].typed;
        it.want.channel_mode = steps[i].mode;
        it.want.transition = steps[i].tr;
        it.want.good_block = steps[i].good;
        it.want.drift_chips = steps[i].drift;
        block_feed.insert(block_feed.size(), it);
      end
    end

    apply_setting(16'd4915, 16'd4915, 16'd3, 16'd8, 16'd4);
    run_sessions(90, 70, 12);
    // zero debounce and timeout, everything good; stall the output meanwhile
    apply_setting(16'h8000, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    hold_req++;
    run_sessions(80, 50, 6);

    send_idle = 54;
    recv_idle = 19;
    apply_setting(16'h7FFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_sessions(60, 50, 10);
    apply_setting(16'd4915, 16'd4915, 16'd4, 16'd4, 16'd3);
    run_sessions(90, 85, 10);

    send_idle = 0;
    recv_idle = 0;
    apply_setting(16'd0, 16'd8192, 16'd2, 16'd6, 16'd5);
    run_sessions(90, 60, 14);
    apply_setting(16'($urandom), 16'($urandom_range(12000)), 16'($urandom_range(6)),
                  16'($urandom_range(12)), 16'($urandom_range(8)));
    run_sessions(50, 60, 12);
    drift_run(1'b1);
    drift_run(1'b0);
    apply_setting(16'd4915, 16'd4915, 16'd50, 16'd200, 16'd200);
    run_sessions(100, 95, 80);

    settle();
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tlsm_pkg.sv
sv/tlsm_drift.sv
sv/tracking_lock_state_manager.sv
tb/tb_top.sv
